/* hw/rtl/hsvcm_pkg.sv */
// Shared constants, register codes and types of the HSV wheel colormap.
package hsvcm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 13;

    localparam logic [LEVEL_W-1:0] Q_ONE        = 13'd4096;
    localparam logic [LEVEL_W-1:0] GREY_SAT_MAX = 13'd8;

    typedef enum logic [2:0] {
        REG_Z_LOW     = 3'd0,
        REG_Z_HIGH    = 3'd1,
        REG_HUE_START = 3'd2,
        REG_HUE_END   = 3'd3,
        REG_SAT_START = 3'd4,
        REG_SAT_END   = 3'd5,
        REG_VAL_START = 3'd6,
        REG_VAL_END   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue_start;
        logic signed [HUE_W-1:0] hue_end;
        logic [LEVEL_W-1:0]      sat_start;
        logic [LEVEL_W-1:0]      sat_end;
        logic [LEVEL_W-1:0]      val_start;
        logic [LEVEL_W-1:0]      val_end;
    } ramp_cfg_t;

endpackage

/* hw/rtl/hsvcm_div_stage.sv */
// One restoring-division step of the range fraction divider.
module hsvcm_div_stage #(
    parameter int SAMPLE_BITS = hsvcm_pkg::SAMPLE_BITS_DEF,
    parameter int QW          = hsvcm_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   valid_in,
    input  logic [SAMPLE_BITS:0]   x_in,
    input  logic [QW-1:0]          q_in,
    input  logic [SAMPLE_BITS-1:0] den,
    output logic                   valid_out,
    output logic [SAMPLE_BITS-1:0] rem_out,
    output logic [QW-1:0]          q_out
);

    logic [SAMPLE_BITS+1:0] trial;
    logic                   bit_take;
    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [SAMPLE_BITS-1:0] rem_next;
    logic [QW-1:0]          q_reg;
    logic [QW-1:0]          q_next;

    always_comb
    begin
        trial    = {1'b0, x_in} - {2'b00, den};
        bit_take = ~trial[SAMPLE_BITS+1];
        rem_next = bit_take ? trial[SAMPLE_BITS-1:0] : x_in[SAMPLE_BITS-1:0];
        q_next   = {q_in[QW-2:0], bit_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;

endmodule

/* hw/rtl/hsvcm_ramp.sv */
// Linear hue, saturation and value ramps driven by the range fraction.
module hsvcm_ramp #(
    parameter int FRAC_BITS = hsvcm_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  hsvcm_pkg::ramp_cfg_t                  cfg,
    input  logic                                  valid_in,
    input  logic [FRAC_BITS:0]                    frac,
    output logic                                  valid_out,
    output logic signed [hsvcm_pkg::HUE_W-1:0]    hue,
    output logic [hsvcm_pkg::LEVEL_W-1:0]         sat,
    output logic [hsvcm_pkg::LEVEL_W-1:0]         val
);

    localparam int HW = hsvcm_pkg::HUE_W;
    localparam int LW = hsvcm_pkg::LEVEL_W;
    localparam int PH = HW + 1 + FRAC_BITS + 2;
    localparam int PL = LW + 1 + FRAC_BITS + 2;

    logic signed [FRAC_BITS+1:0] frac_s;
    logic signed [HW:0]          dh;
    logic signed [LW:0]          ds;
    logic signed [LW:0]          dv;
    logic signed [PH-1:0]        ph_next;
    logic signed [PL-1:0]        ps_next;
    logic signed [PL-1:0]        pv_next;
    logic signed [PH-1:0]        ph_reg;
    logic signed [PL-1:0]        ps_reg;
    logic signed [PL-1:0]        pv_reg;
    logic                        mul_valid_reg;

    logic signed [PH-1:0]        hue_sum;
    logic signed [PL-1:0]        sat_sum;
    logic signed [PL-1:0]        val_sum;
    logic signed [HW-1:0]        hue_next;
    logic [LW-1:0]               sat_next;
    logic [LW-1:0]               val_next;
    logic signed [HW-1:0]        hue_reg;
    logic [LW-1:0]               sat_reg;
    logic [LW-1:0]               val_reg;
    logic                        valid_reg;

    function automatic logic [LW-1:0] clamp_level(input logic signed [PL-1:0] x);
        logic [LW-1:0] r;
        if (x < 0)
        begin
            r = '0;
        end
        else if (x > $signed({{(PL-LW){1'b0}}, hsvcm_pkg::Q_ONE}))
        begin
            r = hsvcm_pkg::Q_ONE;
        end
        else
        begin
            r = x[LW-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        frac_s  = $signed({1'b0, frac});
        dh      = {cfg.hue_end[HW-1], cfg.hue_end} - {cfg.hue_start[HW-1], cfg.hue_start};
        ds      = $signed({1'b0, cfg.sat_end}) - $signed({1'b0, cfg.sat_start});
        dv      = $signed({1'b0, cfg.val_end}) - $signed({1'b0, cfg.val_start});
        ph_next = PH'(dh) * PH'(frac_s);
        ps_next = PL'(ds) * PL'(frac_s);
        pv_next = PL'(dv) * PL'(frac_s);
    end

    always_comb
    begin
        hue_sum  = PH'(cfg.hue_start) + (ph_reg >>> FRAC_BITS);
        sat_sum  = $signed({{(PL-LW){1'b0}}, cfg.sat_start}) + (ps_reg >>> FRAC_BITS);
        val_sum  = $signed({{(PL-LW){1'b0}}, cfg.val_start}) + (pv_reg >>> FRAC_BITS);
        hue_next = hue_sum[HW-1:0];
        sat_next = clamp_level(sat_sum);
        val_next = clamp_level(val_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            mul_valid_reg <= valid_in;
            valid_reg     <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ph_reg  <= ph_next;
            ps_reg  <= ps_next;
            pv_reg  <= pv_next;
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign valid_out = valid_reg;
    assign hue       = hue_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

`ifndef NO_ASSERTIONS
    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (sat_reg <= hsvcm_pkg::Q_ONE) && (val_reg <= hsvcm_pkg::Q_ONE))
        else $error("ramp level above one");
`endif

endmodule

/* hw/rtl/hsvcm_wheel.sv */
// Six-sector HSV wheel that turns hue, saturation and value into an RGB pixel.
module hsvcm_wheel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                valid_in,
    input  logic signed [hsvcm_pkg::HUE_W-1:0]  hue,
    input  logic [hsvcm_pkg::LEVEL_W-1:0]       sat,
    input  logic [hsvcm_pkg::LEVEL_W-1:0]       val,
    output logic                                valid_out,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue
);

    localparam int LW = hsvcm_pkg::LEVEL_W;
    localparam logic [20:0] HUE_BIAS = 21'd393216;

    // Stage C: turn scaling and value scaling.
    logic [19:0]   hu_next;
    logic [19:0]   vv_next;
    logic [19:0]   hu_c_reg;
    logic [19:0]   vv_c_reg;
    logic [LW-1:0] sat_c_reg;
    logic          grey_c_reg;
    logic          valid_c_reg;

    // Stage D: sector, fraction and V*S.
    logic [7:0]    turn6;
    logic [17:0]   div6_prod;
    logic [2:0]    sector_next;
    logic [32:0]   s_next;
    logic [2:0]    sector_d_reg;
    logic [11:0]   f_d_reg;
    logic [19:0]   vv_d_reg;
    logic [32:0]   s_d_reg;
    logic          grey_d_reg;
    logic          valid_d_reg;

    // Stage E: V*S*F, v and p.
    logic [44:0]   sf_next;
    logic [32:0]   p_diff;
    logic [44:0]   sf_e_reg;
    logic [19:0]   vv_e_reg;
    logic [7:0]    v_e_reg;
    logic [7:0]    p_e_reg;
    logic [2:0]    sector_e_reg;
    logic          grey_e_reg;
    logic          valid_e_reg;

    // Stage F: q, t and the sector select.
    logic [43:0]   q_diff;
    logic [7:0]    q_val;
    logic [7:0]    t_val;
    logic [7:0]    red_next;
    logic [7:0]    green_next;
    logic [7:0]    blue_next;
    logic [7:0]    red_reg;
    logic [7:0]    green_reg;
    logic [7:0]    blue_reg;
    logic          grey_f_reg;
    logic          valid_f_reg;

    always_comb
    begin
        hu_next = 20'(21'($signed(hue)) * 21'sd6 + $signed(HUE_BIAS));
        vv_next = 20'({7'd0, val} * 20'd255);
    end

    always_comb
    begin
        turn6       = hu_c_reg[19:12];
        div6_prod   = {10'd0, turn6} * 18'd171;
        sector_next = 3'(turn6 - 8'(div6_prod[17:10] * 8'd6));
        s_next      = {13'd0, vv_c_reg} * {20'd0, sat_c_reg};
    end

    always_comb
    begin
        sf_next = {12'd0, s_d_reg} * {33'd0, f_d_reg};
        p_diff  = {1'b0, vv_d_reg, 12'd0} - s_d_reg;
    end

    always_comb
    begin
        q_diff = {vv_e_reg, 24'd0} - sf_e_reg[43:0];
        q_val  = q_diff[43:36];
        t_val  = p_e_reg + sf_e_reg[43:36];
        if (grey_e_reg)
        begin
            red_next   = v_e_reg;
            green_next = v_e_reg;
            blue_next  = v_e_reg;
        end
        else
        begin
            unique case (sector_e_reg)
                3'd0:
                begin
                    red_next = v_e_reg; green_next = t_val; blue_next = p_e_reg;
                end
                3'd1:
                begin
                    red_next = q_val; green_next = v_e_reg; blue_next = p_e_reg;
                end
                3'd2:
                begin
                    red_next = p_e_reg; green_next = v_e_reg; blue_next = t_val;
                end
                3'd3:
                begin
                    red_next = p_e_reg; green_next = q_val; blue_next = v_e_reg;
                end
                3'd4:
                begin
                    red_next = t_val; green_next = p_e_reg; blue_next = v_e_reg;
                end
                default:
                begin
                    red_next = v_e_reg; green_next = p_e_reg; blue_next = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_c_reg <= valid_in;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= valid_d_reg;
            valid_f_reg <= valid_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hu_c_reg     <= hu_next;
            vv_c_reg     <= vv_next;
            sat_c_reg    <= sat;
            grey_c_reg   <= (sat <= hsvcm_pkg::GREY_SAT_MAX);

            sector_d_reg <= sector_next;
            f_d_reg      <= hu_c_reg[11:0];
            vv_d_reg     <= vv_c_reg;
            s_d_reg      <= s_next;
            grey_d_reg   <= grey_c_reg;

            sf_e_reg     <= sf_next;
            vv_e_reg     <= vv_d_reg;
            v_e_reg      <= vv_d_reg[19:12];
            p_e_reg      <= p_diff[31:24];
            sector_e_reg <= sector_d_reg;
            grey_e_reg   <= grey_d_reg;

            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            grey_f_reg   <= grey_e_reg;
        end
    end

    assign valid_out = valid_f_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef NO_ASSERTIONS
    a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_f_reg && grey_f_reg) |-> (red_reg == green_reg) && (green_reg == blue_reg))
        else $error("grey pixel with unequal channels");
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_d_reg |-> (sector_d_reg <= 3'd5))
        else $error("hue sector out of range");
`endif

endmodule

/* hw/rtl/hsv_wheel_value_colormap_unit.sv */
// Top level of the HSV wheel colormap: configuration, clamp, divider and pixel pipeline.
//
// Each signed data sample is clamped to [z_low, z_high], turned into a fraction of that
// range and mapped through hue, saturation and value ramps to an RGB pixel. The block
// accepts one word per clock cycle while the pipeline advances and returns one pixel per
// word, in order. A divider forms the range fraction one bit per stage, ahead of the
// multiplier stages of the HSV wheel. A stall at the pixel side holds the whole pipeline.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no word is in flight; the block does not enforce this.
module hsv_wheel_value_colormap_unit #(
    parameter int SAMPLE_BITS = hsvcm_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = hsvcm_pkg::FRAC_BITS_DEF,
    parameter int CFG_W       = (SAMPLE_BITS > hsvcm_pkg::HUE_W) ? SAMPLE_BITS : hsvcm_pkg::HUE_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] z_sample,
    output logic                          pixel_valid,
    input  logic                          pixel_ready,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue
);

    localparam int SB = SAMPLE_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int HW = hsvcm_pkg::HUE_W;
    localparam int LW = hsvcm_pkg::LEVEL_W;

    logic signed [SB-1:0] z_low_reg;
    logic signed [SB-1:0] z_high_reg;
    hsvcm_pkg::ramp_cfg_t ramp_cfg_reg;
    logic [SB-1:0]        den_reg;
    logic                 degen_reg;
    logic [SB:0]          den_diff;

    logic                 advance;

    logic signed [SB-1:0] z_clamped;
    logic [SB:0]          num_diff;
    logic [SB-1:0]        num_reg;
    logic                 in_valid_reg;

    logic                 dv_pipe  [0:QW];
    logic [SB-1:0]        rem_pipe [0:QW];
    logic [QW-1:0]        q_pipe   [0:QW];

    logic [FRAC_BITS:0]   frac;

    logic                 ramp_valid;
    logic signed [HW-1:0] hue;
    logic [LW-1:0]        sat;
    logic [LW-1:0]        val;

    assign advance      = ~pixel_valid | pixel_ready;
    assign sample_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_low_reg              <= '0;
            z_high_reg             <= {1'b0, {(SB-1){1'b1}}};
            ramp_cfg_reg.hue_start <= '0;
            ramp_cfg_reg.hue_end   <= 16'sd4096;
            ramp_cfg_reg.sat_start <= hsvcm_pkg::Q_ONE;
            ramp_cfg_reg.sat_end   <= hsvcm_pkg::Q_ONE;
            ramp_cfg_reg.val_start <= hsvcm_pkg::Q_ONE;
            ramp_cfg_reg.val_end   <= hsvcm_pkg::Q_ONE;
        end
        else if (cfg_we)
        begin
            unique case (hsvcm_pkg::cfg_index_t'(cfg_index))
                hsvcm_pkg::REG_Z_LOW:     z_low_reg              <= cfg_data[SB-1:0];
                hsvcm_pkg::REG_Z_HIGH:    z_high_reg             <= cfg_data[SB-1:0];
                hsvcm_pkg::REG_HUE_START: ramp_cfg_reg.hue_start <= cfg_data[HW-1:0];
                hsvcm_pkg::REG_HUE_END:   ramp_cfg_reg.hue_end   <= cfg_data[HW-1:0];
                hsvcm_pkg::REG_SAT_START: ramp_cfg_reg.sat_start <= cfg_data[LW-1:0];
                hsvcm_pkg::REG_SAT_END:   ramp_cfg_reg.sat_end   <= cfg_data[LW-1:0];
                hsvcm_pkg::REG_VAL_START: ramp_cfg_reg.val_start <= cfg_data[LW-1:0];
                hsvcm_pkg::REG_VAL_END:   ramp_cfg_reg.val_end   <= cfg_data[LW-1:0];
                default:                  z_low_reg              <= z_low_reg;
            endcase
        end
    end

    assign den_diff = {z_high_reg[SB-1], z_high_reg} - {z_low_reg[SB-1], z_low_reg};

    always_ff @(posedge clk)
    begin
        den_reg   <= den_diff[SB-1:0];
        degen_reg <= (z_high_reg <= z_low_reg);
    end

    always_comb
    begin
        if (z_sample > z_high_reg)
        begin
            z_clamped = z_high_reg;
        end
        else if (z_sample < z_low_reg)
        begin
            z_clamped = z_low_reg;
        end
        else
        begin
            z_clamped = z_sample;
        end
        num_diff = {z_clamped[SB-1], z_clamped} - {z_low_reg[SB-1], z_low_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg <= num_diff[SB-1:0];
        end
    end

    assign dv_pipe[0]  = in_valid_reg;
    assign rem_pipe[0] = num_reg;
    assign q_pipe[0]   = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [SB:0] x_in;
        if (k == 0)
        begin : g_first
            assign x_in = {1'b0, rem_pipe[k]};
        end
        else
        begin : g_next
            assign x_in = {rem_pipe[k], 1'b0};
        end

        hsvcm_div_stage #(
            .SAMPLE_BITS (SB),
            .QW          (QW)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (dv_pipe[k]),
            .x_in      (x_in),
            .q_in      (q_pipe[k]),
            .den       (den_reg),
            .valid_out (dv_pipe[k+1]),
            .rem_out   (rem_pipe[k+1]),
            .q_out     (q_pipe[k+1])
        );
    end

    assign frac = degen_reg ? '0 : q_pipe[QW];

    hsvcm_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (ramp_cfg_reg),
        .valid_in  (dv_pipe[QW]),
        .frac      (frac),
        .valid_out (ramp_valid),
        .hue       (hue),
        .sat       (sat),
        .val       (val)
    );

    hsvcm_wheel u_wheel (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (ramp_valid),
        .hue       (hue),
        .sat       (sat),
        .val       (val),
        .valid_out (pixel_valid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

`ifndef NO_ASSERTIONS
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_pipe[QW] |-> (frac <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("range fraction above one");
`endif

endmodule
